[rtl/utrd_pkg.sv]
package utrd_pkg;

   // Sizing of the converter
   localparam int MAX_RADIX    = 16;
   localparam int VALUE_BITS   = 64;
   localparam int MAX_DIGITS   = 64;
   localparam int SYMBOL_SLOTS = 16;
   localparam int RADIX_LIMIT  = (MAX_RADIX < SYMBOL_SLOTS) ? MAX_RADIX : SYMBOL_SLOTS;

   // Fixed field widths
   localparam int FIELD_BITS   = 64;
   localparam int CHAR_BITS    = 8;
   localparam int LEN_BITS     = 5;
   localparam int DIGIT_BITS   = 4;
   localparam int SYM_IDX_BITS = 4;
   localparam int CSR_IDX_BITS = 2;

   // One counter serves both the bit sweep (0..VALUE_BITS) and the digit sweep
   localparam int CNT_MAX  = (VALUE_BITS > MAX_DIGITS) ? VALUE_BITS : MAX_DIGITS;
   localparam int CNT_BITS = $clog2(CNT_MAX + 1);

   // Symbols that may not stand in an alphabet
   localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_BITS-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CHAR_FF    = 8'h0C;
   localparam logic [CHAR_BITS-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_BITS-1:0] CHAR_VT    = 8'h0B;
   localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;

   localparam int MIN_RADIX = 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_ERROR,
      ST_EMIT
   } state_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_RADIX_LENGTH  = 2'd0,
      CSR_ALPHABET_LOW  = 2'd1,
      CSR_ALPHABET_HIGH = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic clear;
      logic convert;
      logic shift;
   } digit_ctrl_type;

   typedef struct packed {
      logic done;
      logic error;
   } check_status_type;

   function automatic logic [CHAR_BITS-1:0] symbol_at(
      input logic [FIELD_BITS-1:0]   alpha_low,
      input logic [FIELD_BITS-1:0]   alpha_high,
      input logic [SYM_IDX_BITS-1:0] idx
   );
      logic [FIELD_BITS-1:0] word;
      word = idx[SYM_IDX_BITS-1] ? alpha_high : alpha_low;
      return word[idx[SYM_IDX_BITS-2:0]*CHAR_BITS +: CHAR_BITS];
   endfunction

   function automatic logic forbidden_symbol(input logic [CHAR_BITS-1:0] c);
      return (c == CHAR_PLUS) || (c == CHAR_MINUS) || (c == CHAR_SPACE)
          || (c == CHAR_LF) || (c == CHAR_FF) || (c == CHAR_CR)
          || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_NUL);
   endfunction

endpackage

[rtl/utrd_check.sv]
module utrd_check (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [utrd_pkg::LEN_BITS-1:0]       radix_length,
   input  logic [utrd_pkg::FIELD_BITS-1:0]     alphabet_low,
   input  logic [utrd_pkg::FIELD_BITS-1:0]     alphabet_high,
   output utrd_pkg::check_status_type          status
);

   logic                                running_ff, running_in;
   logic                                error_ff, error_in;
   logic [utrd_pkg::SYM_IDX_BITS-1:0]   idx_ff, idx_in;
   logic [utrd_pkg::CHAR_BITS-1:0]      sym;
   logic                                dup;
   logic                                in_use;

   // Compare the current symbol against every earlier slot
   always_comb begin
      sym = utrd_pkg::symbol_at(alphabet_low, alphabet_high, idx_ff);
      dup = 1'b0;
      for (int j = 0; j < utrd_pkg::SYMBOL_SLOTS; j++) begin
         if ((utrd_pkg::SYM_IDX_BITS'(j) < idx_ff) &&
             (utrd_pkg::symbol_at(alphabet_low, alphabet_high,
                                  utrd_pkg::SYM_IDX_BITS'(j)) == sym)) begin
            dup = 1'b1;
         end
      end
      in_use = ({1'b0, idx_ff} < radix_length);
   end

   always_comb begin
      running_in = running_ff;
      error_in   = error_ff;
      idx_in     = idx_ff;
      if (start) begin
         running_in = 1'b1;
         idx_in     = '0;
         error_in   = (radix_length < utrd_pkg::LEN_BITS'(utrd_pkg::MIN_RADIX))
                   || (radix_length > utrd_pkg::LEN_BITS'(utrd_pkg::RADIX_LIMIT));
      end else if (running_ff) begin
         if (in_use && (utrd_pkg::forbidden_symbol(sym) || dup)) begin
            error_in = 1'b1;
         end
         idx_in = idx_ff + 1'b1;
         if (idx_ff == utrd_pkg::SYM_IDX_BITS'(utrd_pkg::SYMBOL_SLOTS - 1)) begin
            running_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         error_ff   <= 1'b0;
         idx_ff     <= '0;
      end else begin
         running_ff <= running_in;
         error_ff   <= error_in;
         idx_ff     <= idx_in;
      end
   end

   assign status.done  = !running_ff;
   assign status.error = error_ff;

endmodule

[rtl/utrd_digits.sv]
module utrd_digits (
   input  logic                                clock,
   input  utrd_pkg::digit_ctrl_type            ctrl,
   input  logic                                bit_in,
   input  logic [utrd_pkg::LEN_BITS-1:0]       radix_length,
   output logic [utrd_pkg::DIGIT_BITS-1:0]     top_digit
);

   localparam int N = utrd_pkg::MAX_DIGITS;
   localparam int W = utrd_pkg::DIGIT_BITS;

   logic [W-1:0] cell_ff [N];
   logic [W-1:0] cell_in [N];
   logic [W-1:0] conv    [N];
   logic [N-1:0] gen, prop, carry;
   logic [N:0]   sum;
   logic [W:0]   twice;
   logic [W:0]   wide;
   logic         carry_out;

   // Doubling each digit and adding the incoming bit: a cell carries on its
   // own when 2d >= base, and passes the incoming carry on when 2d == base-1.
   // Resolve the whole carry row with one add.
   always_comb begin
      for (int i = 0; i < N; i++) begin
         twice   = {cell_ff[i], 1'b0};
         gen[i]  = (twice >= radix_length);
         prop[i] = (twice == (radix_length - 1'b1));
      end
      sum   = {1'b0, gen | prop} + {1'b0, gen} + {{N{1'b0}}, bit_in};
      carry = sum[N-1:0] ^ (gen | prop) ^ gen;
      for (int i = 0; i < N; i++) begin
         wide      = {cell_ff[i], carry[i]};
         carry_out = gen[i] | (prop[i] & carry[i]);
         conv[i]   = carry_out ? W'(wide - radix_length) : wide[W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < N; i++) begin
         if (ctrl.clear) begin
            cell_in[i] = '0;
         end else if (ctrl.convert) begin
            cell_in[i] = conv[i];
         end else if (ctrl.shift) begin
            cell_in[i] = (i == 0) ? '0 : cell_ff[(i == 0) ? 0 : i - 1];
         end else begin
            cell_in[i] = cell_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   assign top_digit = cell_ff[N-1];

endmodule

[rtl/unsigned_to_radix_digits.sv]
// An accepted value keeps the block busy through the bit sweep and then the digit sweep;
// each digit leaves through the output register in the cycle after its sweep step.
// An invalid alphabet still runs the bit sweep and ends with one error result.
// A value is accepted only while idle, so a new one waits until the last is finished.
// Reset clears control state and the configuration registers to zero.
// Results are one-cycle strobes; the receiver cannot stall them.
module unsigned_to_radix_digits (
   input  logic                                 clock,
   input  logic                                 reset,
   // input transaction
   input  logic                                 start,
   output logic                                 busy,
   input  logic [utrd_pkg::FIELD_BITS-1:0]      req_value,
   // result transactions
   output logic                                 rsp_strobe,
   output logic [utrd_pkg::CHAR_BITS-1:0]       rsp_digit_char,
   output logic                                 rsp_last_digit,
   output logic                                 rsp_alphabet_error,
   // configuration writes
   input  logic                                 csr_write_enable,
   input  logic [utrd_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [utrd_pkg::FIELD_BITS-1:0]      csr_write_data
);

   // State and configuration
   utrd_pkg::state_type                  state_ff, state_in;
   logic [utrd_pkg::LEN_BITS-1:0]        radix_length_ff, radix_length_in;
   logic [utrd_pkg::FIELD_BITS-1:0]      alphabet_low_ff, alphabet_low_in;
   logic [utrd_pkg::FIELD_BITS-1:0]      alphabet_high_ff, alphabet_high_in;

   // Datapath
   logic [utrd_pkg::VALUE_BITS-1:0]      value_ff, value_in;
   logic [utrd_pkg::CNT_BITS-1:0]        count_ff, count_in;
   logic                                 seen_ff, seen_in;

   // Output register
   logic                                 rsp_strobe_ff, rsp_strobe_in;
   logic [utrd_pkg::CHAR_BITS-1:0]       rsp_char_ff, rsp_char_in;
   logic                                 rsp_last_ff, rsp_last_in;
   logic                                 rsp_error_ff, rsp_error_in;

   logic                                 accept;
   logic                                 bits_done;
   logic                                 emit;
   logic [utrd_pkg::DIGIT_BITS-1:0]      top_digit;
   utrd_pkg::digit_ctrl_type             digit_ctrl;
   utrd_pkg::check_status_type           check_status;

   assign busy      = (state_ff != utrd_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign bits_done = (count_ff == utrd_pkg::CNT_BITS'(utrd_pkg::VALUE_BITS));

   // Alphabet check runs alongside the bit sweep, one symbol per cycle
   utrd_check u_check (
      .clock         (clock),
      .reset         (reset),
      .start         (accept),
      .radix_length  (radix_length_ff),
      .alphabet_low  (alphabet_low_ff),
      .alphabet_high (alphabet_high_ff),
      .status        (check_status)
   );

   // Digit cells: bits enter most significant first, digits leave from the top
   utrd_digits u_digits (
      .clock        (clock),
      .ctrl         (digit_ctrl),
      .bit_in       (value_ff[utrd_pkg::VALUE_BITS-1]),
      .radix_length (radix_length_ff),
      .top_digit    (top_digit)
   );

   // Configuration decode; an index beyond the list writes nothing
   always_comb begin
      radix_length_in  = radix_length_ff;
      alphabet_low_in  = alphabet_low_ff;
      alphabet_high_in = alphabet_high_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            utrd_pkg::CSR_RADIX_LENGTH:  radix_length_in  = csr_write_data[utrd_pkg::LEN_BITS-1:0];
            utrd_pkg::CSR_ALPHABET_LOW:  alphabet_low_in  = csr_write_data;
            utrd_pkg::CSR_ALPHABET_HIGH: alphabet_high_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         utrd_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = utrd_pkg::ST_CONVERT;
            end
         end
         utrd_pkg::ST_CONVERT: begin
            // wait for both the bit sweep and the alphabet check
            if (bits_done && check_status.done) begin
               state_in = check_status.error ? utrd_pkg::ST_ERROR : utrd_pkg::ST_EMIT;
            end
         end
         utrd_pkg::ST_ERROR: begin
            state_in = utrd_pkg::ST_IDLE;
         end
         utrd_pkg::ST_EMIT: begin
            if (count_ff == '0) begin
               state_in = utrd_pkg::ST_IDLE;
            end
         end
         default: state_in = utrd_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath control
   always_comb begin
      digit_ctrl    = '0;
      value_in      = value_ff;
      count_in      = count_ff;
      seen_in       = seen_ff;
      emit          = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_char_in   = '0;
      rsp_last_in   = 1'b0;
      rsp_error_in  = 1'b0;
      unique case (state_ff)
         utrd_pkg::ST_IDLE: begin
            if (accept) begin
               // load the value, clear the cells and the leading-zero flag
               digit_ctrl.clear = 1'b1;
               value_in         = req_value[utrd_pkg::VALUE_BITS-1:0];
               count_in         = '0;
               seen_in          = 1'b0;
            end
         end
         utrd_pkg::ST_CONVERT: begin
            if (!bits_done) begin
               digit_ctrl.convert = 1'b1;
               value_in           = value_ff << 1;
               count_in           = count_ff + 1'b1;
            end else if (check_status.done) begin
               count_in = utrd_pkg::CNT_BITS'(utrd_pkg::MAX_DIGITS - 1);
            end
         end
         utrd_pkg::ST_ERROR: begin
            rsp_strobe_in = 1'b1;
            rsp_last_in   = 1'b1;
            rsp_error_in  = 1'b1;
         end
         utrd_pkg::ST_EMIT: begin
            // drop leading zeros; the bottom digit always goes out
            emit             = seen_ff || (top_digit != '0) || (count_ff == '0);
            digit_ctrl.shift = 1'b1;
            count_in         = count_ff - 1'b1;
            seen_in          = seen_ff || emit;
            rsp_strobe_in    = emit;
            rsp_char_in      = utrd_pkg::symbol_at(alphabet_low_ff, alphabet_high_ff, top_digit);
            rsp_last_in      = (count_ff == '0);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= utrd_pkg::ST_IDLE;
         radix_length_ff  <= '0;
         alphabet_low_ff  <= '0;
         alphabet_high_ff <= '0;
         rsp_strobe_ff    <= 1'b0;
         count_ff         <= '0;
         seen_ff          <= 1'b0;
      end else begin
         state_ff         <= state_in;
         radix_length_ff  <= radix_length_in;
         alphabet_low_ff  <= alphabet_low_in;
         alphabet_high_ff <= alphabet_high_in;
         rsp_strobe_ff    <= rsp_strobe_in;
         count_ff         <= count_in;
         seen_ff          <= seen_in;
      end
   end

   // Payload registers hold without reset
   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_digit_char     = rsp_char_ff;
   assign rsp_last_digit     = rsp_last_ff;
   assign rsp_alphabet_error = rsp_error_ff;

endmodule

[sim/radix_digit_checker.sv]
`timescale 1ns / 100ps

module radix_digit_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic [utrd_pkg::FIELD_BITS-1:0]      req_value,
   input  logic                                 rsp_strobe,
   input  logic [utrd_pkg::CHAR_BITS-1:0]       rsp_digit_char,
   input  logic                                 rsp_last_digit,
   input  logic                                 rsp_alphabet_error,
   input  logic                                 csr_write_enable,
   input  logic [utrd_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [utrd_pkg::FIELD_BITS-1:0]      csr_write_data,
   output int                                   fail_count,
   output int                                   pending_count,
   output int                                   digits_checked,
   output int                                   errors_checked
);

   localparam logic [utrd_pkg::FIELD_BITS-1:0] VALUE_MASK =
      (utrd_pkg::VALUE_BITS >= utrd_pkg::FIELD_BITS) ? {utrd_pkg::FIELD_BITS{1'b1}}
      : ((64'd1 << utrd_pkg::VALUE_BITS) - 64'd1);

   typedef struct packed {
      logic [utrd_pkg::CHAR_BITS-1:0] digit_char;
      logic                           last_digit;
      logic                           alphabet_error;
   } digit_result_type;

   // shadow copy of the block's registers
   logic [utrd_pkg::LEN_BITS-1:0]   radix_len_q;
   logic [utrd_pkg::FIELD_BITS-1:0] alpha_low_q;
   logic [utrd_pkg::FIELD_BITS-1:0] alpha_high_q;

   digit_result_type expected_digits[$];
   int               mismatches;
   int               n_digits;
   int               n_errors;

   function automatic logic [utrd_pkg::CHAR_BITS-1:0] symbol_of(input int idx);
      logic [2*utrd_pkg::FIELD_BITS-1:0] alpha;
      alpha = {alpha_high_q, alpha_low_q};
      return alpha[idx*utrd_pkg::CHAR_BITS +: utrd_pkg::CHAR_BITS];
   endfunction

   function automatic bit is_banned(input logic [utrd_pkg::CHAR_BITS-1:0] c);
      return c == utrd_pkg::CHAR_PLUS || c == utrd_pkg::CHAR_MINUS
          || c == utrd_pkg::CHAR_SPACE || c == utrd_pkg::CHAR_LF
          || c == utrd_pkg::CHAR_FF || c == utrd_pkg::CHAR_CR
          || c == utrd_pkg::CHAR_TAB || c == utrd_pkg::CHAR_VT
          || c == utrd_pkg::CHAR_NUL;
   endfunction

   // base in use, or zero when the alphabet cannot be used
   function automatic int unsigned usable_base();
      int len;
      len = int'(radix_len_q);
      if (len < utrd_pkg::MIN_RADIX || len > utrd_pkg::RADIX_LIMIT)
         return 0;
      for (int i = 0; i < len; i++) begin
         if (is_banned(symbol_of(i)))
            return 0;
         for (int j = 0; j < i; j++)
            if (symbol_of(j) == symbol_of(i))
               return 0;
      end
      return len;
   endfunction

   task automatic predict_conversion(input logic [utrd_pkg::FIELD_BITS-1:0] value);
      int unsigned                     base;
      logic [utrd_pkg::FIELD_BITS-1:0] quot;
      logic [utrd_pkg::DIGIT_BITS-1:0] digits [utrd_pkg::MAX_DIGITS];
      int                              n;
      digit_result_type                r;
      base = usable_base();
      if (base == 0) begin
         r.digit_char     = '0;
         r.last_digit     = 1'b1;
         r.alphabet_error = 1'b1;
         expected_digits.push_back(r);
         return;
      end
      quot = value & VALUE_MASK;
      n    = 0;
      // least significant digit first, keep at most MAX_DIGITS of them
      do begin
         if (n < utrd_pkg::MAX_DIGITS) begin
            digits[n] = utrd_pkg::DIGIT_BITS'(quot % base);
            n++;
         end
         quot = quot / base;
      end while (quot != 0);
      for (int k = n - 1; k >= 0; k--) begin
         r.digit_char     = symbol_of(int'(digits[k]));
         r.last_digit     = (k == 0);
         r.alphabet_error = 1'b0;
         expected_digits.push_back(r);
      end
   endtask

   always @(posedge clock) begin : monitor
      digit_result_type got;
      digit_result_type want;
      if (reset) begin
         radix_len_q  = '0;
         alpha_low_q  = '0;
         alpha_high_q = '0;
         expected_digits.delete();
         mismatches = 0;
         n_digits   = 0;
         n_errors   = 0;
      end else begin
         // check results before queuing new work
         if (rsp_strobe) begin
            got.digit_char     = rsp_digit_char;
            got.last_digit     = rsp_last_digit;
            got.alphabet_error = rsp_alphabet_error;
            if (expected_digits.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected result: char %h last %b error %b",
                           $realtime, got.digit_char, got.last_digit,
                           got.alphabet_error);
               mismatches++;
            end else begin
               want = expected_digits.pop_front();
               if (want.alphabet_error)
                  n_errors++;
               else
                  n_digits++;
               if (got.digit_char !== want.digit_char || got.last_digit !== want.last_digit
                   || got.alphabet_error !== want.alphabet_error) begin
                  if (mismatches < 10)
                     $display("%0t: mismatch: char %h/%h last %b/%b error %b/%b (exp/act)",
                              $realtime, want.digit_char, got.digit_char,
                              want.last_digit, got.last_digit,
                              want.alphabet_error, got.alphabet_error);
                  mismatches++;
               end
            end
         end
         if (start && !busy)
            predict_conversion(req_value);
         if (csr_write_enable) begin
            if (csr_index == utrd_pkg::CSR_RADIX_LENGTH)
               radix_len_q = csr_write_data[utrd_pkg::LEN_BITS-1:0];
            else if (csr_index == utrd_pkg::CSR_ALPHABET_LOW)
               alpha_low_q = csr_write_data;
            else if (csr_index == utrd_pkg::CSR_ALPHABET_HIGH)
               alpha_high_q = csr_write_data;
         end
      end
      fail_count     <= mismatches;
      pending_count  <= expected_digits.size();
      digits_checked <= n_digits;
      errors_checked <= n_errors;
   end

endmodule

[sim/unsigned_to_radix_digits_tb.sv]
`timescale 1ns / 100ps

module unsigned_to_radix_digits_tb;

   // cycles with no transaction of any kind before the run is declared hung
   localparam int WATCHDOG_LIMIT = 2000;
   // index with no register behind it; writes there must change nothing
   localparam logic [utrd_pkg::CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int PHASE_ITEMS = 145;

   logic                               clock;
   logic                               reset            = 1'b1;
   logic                               start            = 1'b0;
   logic [utrd_pkg::FIELD_BITS-1:0]    req_value        = '0;
   logic                               csr_write_enable = 1'b0;
   logic [utrd_pkg::CSR_IDX_BITS-1:0]  csr_index        = utrd_pkg::CSR_RADIX_LENGTH;
   logic [utrd_pkg::FIELD_BITS-1:0]    csr_write_data   = '0;
   logic                               busy;
   logic                               rsp_strobe;
   logic [utrd_pkg::CHAR_BITS-1:0]     rsp_digit_char;
   logic                               rsp_last_digit;
   logic                               rsp_alphabet_error;

   int fail_count;
   int pending_count;
   int digits_checked;
   int errors_checked;

   int sender_idle_pct = 12;
   int values_sent     = 0;
   int settings_used   = 0;
   int quiet_cycles    = 0;

   // symbols that make an alphabet unusable, as a lookup for the stimulus
   logic [utrd_pkg::CHAR_BITS-1:0] banned_chars [9] = '{
      utrd_pkg::CHAR_PLUS, utrd_pkg::CHAR_MINUS, utrd_pkg::CHAR_SPACE, utrd_pkg::CHAR_LF,
      utrd_pkg::CHAR_FF, utrd_pkg::CHAR_CR, utrd_pkg::CHAR_TAB, utrd_pkg::CHAR_VT,
      utrd_pkg::CHAR_NUL};

   unsigned_to_radix_digits DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_value          (req_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_digit_char     (rsp_digit_char),
      .rsp_last_digit     (rsp_last_digit),
      .rsp_alphabet_error (rsp_alphabet_error),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   radix_digit_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_value          (req_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_digit_char     (rsp_digit_char),
      .rsp_last_digit     (rsp_last_digit),
      .rsp_alphabet_error (rsp_alphabet_error),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .digits_checked     (digits_checked),
      .errors_checked     (errors_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: restart the count on every input, result or register
   // transaction; give up once the block has been silent for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_write_enable)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Drop start and hold until every expected digit has arrived and the
   // block reports idle. pending_count and busy both change on clock edges
   // only, so sampling them here is free of races.
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0 || busy);
   endtask

   task automatic write_reg(input logic [utrd_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [utrd_pkg::FIELD_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // Write all three registers while the block is idle. The length word may
   // carry junk above bit 4; only the low five bits count.
   task automatic apply_setting(input logic [utrd_pkg::FIELD_BITS-1:0] len_word,
                                input logic [utrd_pkg::FIELD_BITS-1:0] alpha_low,
                                input logic [utrd_pkg::FIELD_BITS-1:0] alpha_high);
      wait_idle();
      write_reg(utrd_pkg::CSR_RADIX_LENGTH, len_word);
      write_reg(utrd_pkg::CSR_ALPHABET_LOW, alpha_low);
      write_reg(utrd_pkg::CSR_ALPHABET_HIGH, alpha_high);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // Offer one value. A random idle gap before it lets start rise
   // at any point of the block's bit sweep or digit sweep, or well after it.
   // Start stays high after acceptance so back-to-back values need no
   // second assignment in the same step.
   task automatic send_value(input logic [utrd_pkg::FIELD_BITS-1:0] value);
      int gap;
      gap = 0;
      if ($urandom_range(99) < sender_idle_pct)
         gap = $urandom_range(1, 160);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
      values_sent++;
   endtask

   function automatic logic [utrd_pkg::FIELD_BITS-1:0] random_value();
      logic [utrd_pkg::FIELD_BITS-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(7))
         0: v = 64'($urandom_range(0, 40));
         1: v = v >> $urandom_range(0, 63);
         2: v = ~64'd0 - $urandom_range(0, 3);
         3: v = (64'd1 << $urandom_range(0, 63)) - $urandom_range(0, 1);
         default: ;
      endcase
      return v;
   endfunction

   function automatic bit is_banned_char(input logic [utrd_pkg::CHAR_BITS-1:0] c);
      foreach (banned_chars[i])
         if (banned_chars[i] == c)
            return 1'b1;
      return 1'b0;
   endfunction

   // Build a random setting: mostly usable alphabets of random length, with
   // a share of bad lengths, banned symbols and repeated symbols. Slots past
   // the length are left random, banned symbols included.
   task automatic pick_setting(output logic [utrd_pkg::FIELD_BITS-1:0] len_word,
                               output logic [utrd_pkg::FIELD_BITS-1:0] alpha_low,
                               output logic [utrd_pkg::FIELD_BITS-1:0] alpha_high);
      logic [2*utrd_pkg::FIELD_BITS-1:0] alpha;
      logic [utrd_pkg::CHAR_BITS-1:0]    c;
      int                                len;
      int                                roll;
      int                                a;
      int                                b;
      bit                                clash;
      alpha = {$urandom, $urandom, $urandom, $urandom};
      roll  = $urandom_range(99);
      if (roll < 12)
         len = utrd_pkg::MIN_RADIX;
      else if (roll < 24)
         len = utrd_pkg::RADIX_LIMIT;
      else
         len = $urandom_range(utrd_pkg::MIN_RADIX, utrd_pkg::RADIX_LIMIT);
      for (int i = 0; i < len; i++) begin
         do begin
            c     = utrd_pkg::CHAR_BITS'($urandom_range(1, 255));
            clash = is_banned_char(c);
            for (int j = 0; j < i; j++)
               if (alpha[j*utrd_pkg::CHAR_BITS +: utrd_pkg::CHAR_BITS] == c)
                  clash = 1'b1;
         end while (clash);
         alpha[i*utrd_pkg::CHAR_BITS +: utrd_pkg::CHAR_BITS] = c;
      end
      roll = $urandom_range(99);
      if (roll < 6) begin
         // length outside the usable range
         case ($urandom_range(2))
            0: len = 0;
            1: len = 1;
            default: len = $urandom_range(utrd_pkg::RADIX_LIMIT + 1, 31);
         endcase
      end else if (roll < 12) begin
         alpha[$urandom_range(0, len - 1)*utrd_pkg::CHAR_BITS +: utrd_pkg::CHAR_BITS] =
            banned_chars[$urandom_range(0, 8)];
      end else if (roll < 18) begin
         b = $urandom_range(1, len - 1);
         a = $urandom_range(0, b - 1);
         alpha[b*utrd_pkg::CHAR_BITS +: utrd_pkg::CHAR_BITS] =
            alpha[a*utrd_pkg::CHAR_BITS +: utrd_pkg::CHAR_BITS];
      end
      len_word = {$urandom, $urandom};
      len_word[utrd_pkg::LEN_BITS-1:0] = utrd_pkg::LEN_BITS'(len);
      alpha_low  = alpha[utrd_pkg::FIELD_BITS-1:0];
      alpha_high = alpha[2*utrd_pkg::FIELD_BITS-1:utrd_pkg::FIELD_BITS];
   endtask

   initial begin : stimulus
      logic [utrd_pkg::FIELD_BITS-1:0] hex_low;
      logic [utrd_pkg::FIELD_BITS-1:0] hex_high;
      logic [utrd_pkg::FIELD_BITS-1:0] len_word;
      logic [utrd_pkg::FIELD_BITS-1:0] alpha_low;
      logic [utrd_pkg::FIELD_BITS-1:0] alpha_high;
      logic [utrd_pkg::FIELD_BITS-1:0] bad_low;
      logic [utrd_pkg::FIELD_BITS-1:0] bad_high;
      int                              phase_items;
      int                              group;
      int                              pos;

      hex_low  = "76543210";
      hex_high = "FEDCBA98";

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // registers straight out of reset: length zero, so an error result
      send_value(64'd0);

      // lengths of one, seventeen and thirty-one (junk above the length field)
      apply_setting(64'd1, hex_low, hex_high);
      send_value(64'd5);
      apply_setting(64'hFFFF_FFFF_FFFF_FFF1, hex_low, hex_high);
      send_value(64'd5);
      apply_setting(64'h0000_0000_0000_001F, hex_low, hex_high);
      send_value(64'd5);

      // each banned symbol placed somewhere inside a full-length alphabet
      foreach (banned_chars[i]) begin
         pos = (i * 5) % 16;
         {bad_high, bad_low} = {hex_high, hex_low};
         if (pos < 8)
            bad_low[pos*8 +: 8] = banned_chars[i];
         else
            bad_high[(pos-8)*8 +: 8] = banned_chars[i];
         apply_setting(64'd16, bad_low, bad_high);
         send_value(64'hFEDC_BA98_7654_3210);
      end

      // last symbol repeats an earlier one
      bad_high = hex_high;
      bad_high[63:56] = hex_low[31:24];
      apply_setting(64'd16, hex_low, bad_high);
      send_value(64'd255);

      // binary: zero, one, the 64-digit maximum and the top bit alone;
      // the unused index is written too and must change nothing
      apply_setting(64'd2, 64'("01"), 64'd0);
      wait_idle();
      write_reg(CSR_UNUSED, ~64'd0);
      csr_write_enable <= 1'b0;
      send_value(64'd0);
      send_value(64'd1);
      send_value(~64'd0);
      send_value(64'h8000_0000_0000_0000);

      // hexadecimal, the widest base
      apply_setting(64'd16, hex_low, hex_high);
      send_value(64'd0);
      send_value(~64'd0);
      send_value(64'h0123_4567_89AB_CDEF);

      // decimal and base three
      apply_setting(64'd10, hex_low, hex_high);
      send_value(~64'd0);
      send_value(64'd10);
      apply_setting(64'd3, 64'("zyx"), 64'd0);
      send_value(~64'd0);

      // --- random part: three rounds of sender idling ---
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: sender_idle_pct = 12;
            1: sender_idle_pct = 55;
            default: sender_idle_pct = 0;
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            pick_setting(len_word, alpha_low, alpha_high);
            apply_setting(len_word, alpha_low, alpha_high);
            group = $urandom_range(3, 12);
            repeat (group) begin
               send_value(random_value());
               phase_items++;
            end
         end
      end

      // drain, then allow one full conversion's worth of settling
      wait_idle();
      repeat (140) @(posedge clock);

      $display("Converted %0d values under %0d register settings, sender idle 12/55/0 pct.",
               values_sent, settings_used);
      $display("Compared %0d digit results and %0d alphabet-error results.",
               digits_checked, errors_checked);
      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results never arrived", fail_count, pending_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/utrd_pkg.sv
rtl/utrd_check.sv
rtl/utrd_digits.sv
rtl/unsigned_to_radix_digits.sv
sim/radix_digit_checker.sv
sim/unsigned_to_radix_digits_tb.sv
